>>> hdl/blme_pkg.sv
// shared constants, types and state encoding for the beat level meter envelope
// no dependencies; imported by blme_div and beat_level_meter_envelope
package blme_pkg;

  localparam int LEVEL_WIDTH = 16;
  localparam int FRAC_BITS   = LEVEL_WIDTH - 2;
  localparam int CFG_WIDTH   = 16;
  localparam int VOL_SHIFT   = 14;
  localparam int ATTACK_SHIFT = 14;
  localparam int DECAY_SHIFT  = 16;

  localparam int DIVIDEND_WIDTH = LEVEL_WIDTH + VOL_SHIFT;
  localparam int DIV_STEPS      = DIVIDEND_WIDTH;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam int PROD_WIDTH = LEVEL_WIDTH + CFG_WIDTH;
  localparam int CMP_WIDTH  = LEVEL_WIDTH + 5;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_ONE   = LEVEL_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_TENTH =
    LEVEL_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX   = '1;

  localparam logic [1:0] TICK_MAX = 2'd3;

  localparam logic [CFG_WIDTH-1:0] VOLUME_RESET = 16'd13107;
  localparam logic [CFG_WIDTH-1:0] DECAY_RESET  = 16'd60293;
  localparam logic [CFG_WIDTH-1:0] ATTACK_RESET = 16'd23921;

  typedef enum logic [1:0] {
    CFG_VOLUME = 2'd0,
    CFG_DECAY  = 2'd1,
    CFG_ATTACK = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_MUL,
    ST_WB
  } state_e;

  typedef struct packed {
    logic                      start;
    logic [DIVIDEND_WIDTH-1:0] dividend;
    logic [CFG_WIDTH-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic [DIVIDEND_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hdl/blme_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on blme_pkg for widths and the request/response structs
module blme_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blme_pkg::div_req_t req_i,
  output blme_pkg::div_rsp_t rsp_o
);
  import blme_pkg::*;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_WIDTH-1:0] dvd_q, dvd_d;
  logic [CFG_WIDTH-1:0]      rem_q, rem_d;
  logic [CFG_WIDTH-1:0]      den_q, den_d;
  logic [CFG_WIDTH:0]        trial;
  logic [CFG_WIDTH+1:0]      diff;

  assign trial = {rem_q, dvd_q[DIVIDEND_WIDTH-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the divisor width
      if (!diff[CFG_WIDTH+1]) begin
        rem_d = diff[CFG_WIDTH-1:0];
      end else begin
        rem_d = trial[CFG_WIDTH-1:0];
      end
      dvd_d = {dvd_q[DIVIDEND_WIDTH-2:0], ~diff[CFG_WIDTH+1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q)
    else $error("divider done and busy together");

endmodule

>>> hdl/beat_level_meter_envelope.sv
// beat level meter envelope: normalize, attack/decay choice, floor and saturation
// depends on blme_pkg and blme_div
// path from the accepting edge to out_valid_o: a reset item goes straight to writeback,
//   a zero-volume tick runs calc, multiply, writeback; nonzero volume first runs the divider
// throughput: one item at a time, the next taken after writeback; a held result stalls this
// reset: previous level 0.1, peak and tick count zero, registers to defaults
module beat_level_meter_envelope (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [blme_pkg::CFG_WIDTH-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [blme_pkg::LEVEL_WIDTH-1:0] peak_level_i,
  input  logic                             music_playing_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [blme_pkg::LEVEL_WIDTH-1:0] meter_value_o
);
  import blme_pkg::*;

  state_e state_q, state_d;

  logic [CFG_WIDTH-1:0]   vol_q, decay_q, attack_q;
  logic [LEVEL_WIDTH-1:0] level_q, peak_q;
  logic [1:0]             ticks_q;
  logic [LEVEL_WIDTH-1:0] lvl_q, m_q, out_q;
  logic                   hold_q, clear_q, out_valid_q;
  logic [PROD_WIDTH-1:0]  prod_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      accept, commit;
  logic [LEVEL_WIDTH-1:0]    lvl_in;
  logic [DIVIDEND_WIDTH-1:0] quo_clamped;
  logic [LEVEL_WIDTH-1:0]    m_cur;
  logic                      hold_cur;
  logic [CMP_WIDTH-1:0]      m10, m20, prev11, prev5, peak19, peak_ext;
  logic [PROD_WIDTH-1:0]     mul_a, mul_b;
  logic [PROD_WIDTH-ATTACK_SHIFT-1:0] att_full;
  logic [LEVEL_WIDTH-1:0]    env_res, res;
  logic                      at_floor;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign lvl_in = music_playing_i ? peak_level_i : '0;

  assign div_req.start    = accept && !op_i && (vol_q != '0);
  assign div_req.dividend = {lvl_in, VOL_SHIFT'(0)};
  assign div_req.divisor  = vol_q;

  blme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo_clamped = (div_rsp.quotient > DIVIDEND_WIDTH'(LEVEL_ONE)) ?
                       DIVIDEND_WIDTH'(LEVEL_ONE) : div_rsp.quotient;

  // hold selects the decay path, otherwise a new peak is taken with the attack gain
  assign m_cur    = LEVEL_TENTH + lvl_q;
  assign m10      = CMP_WIDTH'(m_cur) * CMP_WIDTH'(10);
  assign m20      = CMP_WIDTH'(m_cur) * CMP_WIDTH'(20);
  assign prev11   = CMP_WIDTH'(level_q) * CMP_WIDTH'(11);
  assign prev5    = CMP_WIDTH'(level_q) * CMP_WIDTH'(5);
  assign peak19   = CMP_WIDTH'(peak_q) * CMP_WIDTH'(19);
  assign peak_ext = CMP_WIDTH'(peak_q);
  assign hold_cur = (ticks_q < TICK_MAX) || (m10 < prev11) ||
                    ((m20 < peak19) && (prev5 > peak_ext));

  // one shared multiplier, operands picked by the path
  assign mul_a = hold_q ? PROD_WIDTH'(level_q) : PROD_WIDTH'(m_q);
  assign mul_b = hold_q ? PROD_WIDTH'(decay_q) : PROD_WIDTH'(attack_q);

  assign att_full = prod_q[PROD_WIDTH-1:ATTACK_SHIFT];
  always_comb begin
    if (hold_q) begin
      env_res = prod_q[DECAY_SHIFT +: LEVEL_WIDTH];
    end else if (att_full > (PROD_WIDTH-ATTACK_SHIFT)'(LEVEL_MAX)) begin
      env_res = LEVEL_MAX;
    end else begin
      env_res = att_full[LEVEL_WIDTH-1:0];
    end
  end
  assign at_floor = (env_res <= LEVEL_TENTH);
  assign res      = at_floor ? LEVEL_TENTH : env_res;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i) begin
            state_d = ST_WB;
          end else if (vol_q == '0) begin
            state_d = ST_CALC;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: state_d = ST_MUL;
      ST_MUL:  state_d = ST_WB;
      ST_WB: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vol_q       <= VOLUME_RESET;
      decay_q     <= DECAY_RESET;
      attack_q    <= ATTACK_RESET;
      level_q     <= LEVEL_TENTH;
      peak_q      <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_VOLUME: vol_q    <= cfg_data_i;
          CFG_DECAY:  decay_q  <= cfg_data_i;
          CFG_ATTACK: attack_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (clear_q) begin
          level_q <= LEVEL_TENTH;
          peak_q  <= '0;
          ticks_q <= '0;
        end else begin
          level_q <= res;
          if (at_floor) begin
            peak_q <= '0;
          end else if (!hold_q) begin
            peak_q <= m_q;
          end
          if (!hold_q) begin
            ticks_q <= 2'd1;
          end else if (ticks_q < TICK_MAX) begin
            ticks_q <= ticks_q + 2'd1;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clear_q <= op_i;
      if (!op_i && (vol_q == '0)) begin
        lvl_q <= (lvl_in > LEVEL_ONE) ? LEVEL_ONE : lvl_in;
      end
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      lvl_q <= quo_clamped[LEVEL_WIDTH-1:0];
    end
    if (state_q == ST_CALC) begin
      m_q    <= m_cur;
      hold_q <= hold_cur;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (commit) begin
      out_q <= clear_q ? LEVEL_TENTH : res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign meter_value_o = out_q;

  a_out_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (meter_value_o >= LEVEL_TENTH))
    else $error("meter value below the floor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("new item taken while one is in work");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_level_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(commit) |-> (level_q == out_q))
    else $error("stored level differs from delivered meter value");

endmodule

>>> test/beat_level_meter_envelope_tb.sv
// self-checking testbench for the beat level meter envelope: directed and random ticks
// depends on blme_pkg and beat_level_meter_envelope; predicts every meter value in line
module beat_level_meter_envelope_tb;
  import blme_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 50;

  typedef struct packed {
    logic                   op;
    logic [LEVEL_WIDTH-1:0] peak;
    logic                   playing;
  } tick_item_t;

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i     = '0;
  logic [CFG_WIDTH-1:0]   cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic                   op_i            = 1'b0;
  logic [LEVEL_WIDTH-1:0] peak_level_i    = '0;
  logic                   music_playing_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic [LEVEL_WIDTH-1:0] meter_value_o;

  beat_level_meter_envelope dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .peak_level_i    (peak_level_i),
    .music_playing_i (music_playing_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .meter_value_o   (meter_value_o)
  );

  // envelope state and register copies
  logic [CFG_WIDTH-1:0]   vol_setting    = VOLUME_RESET;
  logic [CFG_WIDTH-1:0]   decay_setting  = DECAY_RESET;
  logic [CFG_WIDTH-1:0]   attack_setting = ATTACK_RESET;
  logic [LEVEL_WIDTH-1:0] env_meter      = LEVEL_TENTH;
  logic [LEVEL_WIDTH-1:0] env_prev       = LEVEL_TENTH;
  logic [LEVEL_WIDTH-1:0] env_peak       = '0;
  logic [1:0]             env_ticks      = '0;

  tick_item_t             tick_items_q[$];
  logic [LEVEL_WIDTH-1:0] meter_expected_q[$];
  tick_item_t             drive_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_active    = 1'b0;
  int rx_hold_cnt    = 0;
  int quiet_cycles   = 0;
  int error_count    = 0;

  function automatic logic [LEVEL_WIDTH-1:0] predict_meter(tick_item_t it);
    logic [63:0] lvl;
    logic [63:0] m;
    logic        take_decay;
    if (it.op) begin
      env_meter = LEVEL_TENTH;
      env_prev  = LEVEL_TENTH;
      env_peak  = '0;
      env_ticks = '0;
      return LEVEL_TENTH;
    end
    lvl = it.playing ? 64'(it.peak) : 64'd0;
    if (vol_setting != 0) lvl = (lvl << VOL_SHIFT) / 64'(vol_setting);
    if (lvl > 64'(LEVEL_ONE)) lvl = 64'(LEVEL_ONE);
    m = 64'(LEVEL_TENTH) + lvl;
    take_decay = (env_ticks < TICK_MAX) ||
                 (m * 64'd10 < 64'(env_prev) * 64'd11) ||
                 ((m * 64'd20 < 64'(env_peak) * 64'd19) &&
                  (64'(env_prev) * 64'd5 > 64'(env_peak)));
    if (take_decay) begin
      m = (64'(env_prev) * 64'(decay_setting)) >> DECAY_SHIFT;
    end else begin
      env_ticks = '0;
      env_peak  = m[LEVEL_WIDTH-1:0];
      m = (m * 64'(attack_setting)) >> ATTACK_SHIFT;
      if (m > 64'(LEVEL_MAX)) m = 64'(LEVEL_MAX);
    end
    // floor at 0.1 also forgets the recorded peak
    if (m <= 64'(LEVEL_TENTH)) begin
      m = 64'(LEVEL_TENTH);
      env_peak = '0;
    end
    env_meter = m[LEVEL_WIDTH-1:0];
    env_prev  = m[LEVEL_WIDTH-1:0];
    if (env_ticks < TICK_MAX) env_ticks = env_ticks + 2'd1;
    return env_meter;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && tick_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = tick_items_q.pop_front();
        in_valid_i      <= 1'b1;
        op_i            <= drive_item.op;
        peak_level_i    <= drive_item.peak;
        music_playing_i <= drive_item.playing;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off during the pressure phase
  always @(posedge clk_i) begin
    if (hold_active && rx_hold_cnt < HOLD_CYCLES) begin
      out_ready_i <= 1'b0;
      rx_hold_cnt <= rx_hold_cnt + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_active) rx_hold_cnt <= 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        meter_expected_q.insert(meter_expected_q.size(),
                                predict_meter('{op_i, peak_level_i, music_playing_i}));
      if (out_valid_o && out_ready_i) begin
        if (meter_expected_q.size() == 0) begin
          $display("%0t: unexpected meter_value, expected none, actual %0d",
                   $time, meter_value_o);
          error_count++;
        end else if (meter_value_o !== meter_expected_q[0]) begin
          $display("%0t: meter_value mismatch, expected %0d, actual %0d",
                   $time, meter_expected_q[0], meter_value_o);
          error_count++;
          void'(meter_expected_q.pop_front());
        end else begin
          void'(meter_expected_q.pop_front());
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_setting(input cfg_idx_e idx, input logic [CFG_WIDTH-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_VOLUME: vol_setting    = data;
      CFG_DECAY:  decay_setting  = data;
      CFG_ATTACK: attack_setting = data;
      default: ;
    endcase
  endtask

  task automatic queue_tick(input logic op, input logic [LEVEL_WIDTH-1:0] peak,
                            input logic playing);
    tick_items_q.insert(tick_items_q.size(), '{op, peak, playing});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_items_q.size() != 0 || in_valid_i || meter_expected_q.size() != 0);
  endtask

  // mostly beats: a few quiet ticks then a loud one, plus noise and meter resets
  task automatic add_beat_items(input int n_items);
    int added;
    int r;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(99);
      if (r < 4) begin
        queue_tick(1'b1, LEVEL_WIDTH'($urandom), 1'($urandom));
        added++;
      end else if (r < 14) begin
        queue_tick(1'b0, LEVEL_WIDTH'($urandom), 1'($urandom));
        added++;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_tick(1'b0, LEVEL_WIDTH'($urandom_range(0, 4095)), $urandom_range(99) < 90);
          added++;
        end
        queue_tick(1'b0, LEVEL_WIDTH'($urandom_range(4096, 65535)), 1'b1);
        added++;
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_WIDTH-1:0] vol, input logic [CFG_WIDTH-1:0] dec,
                           input logic [CFG_WIDTH-1:0] att, input int send_pct,
                           input int recv_pct, input int n_items);
    write_setting(CFG_VOLUME, vol);
    write_setting(CFG_DECAY, dec);
    write_setting(CFG_ATTACK, att);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_beat_items(n_items);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks on the default registers
    write_setting(CFG_VOLUME, VOLUME_RESET);
    write_setting(CFG_DECAY, DECAY_RESET);
    write_setting(CFG_ATTACK, ATTACK_RESET);
    queue_tick(1'b1, 16'hFFFF, 1'b1);
    queue_tick(1'b0, 16'hFFFF, 1'b0);
    queue_tick(1'b0, 16'h0000, 1'b1);
    queue_tick(1'b0, 16'h0001, 1'b1);
    queue_tick(1'b0, 16'hFFFF, 1'b1);
    repeat (4) queue_tick(1'b0, 16'h0000, 1'b1);
    queue_tick(1'b0, 16'h8000, 1'b1);
    queue_tick(1'b0, 16'h7FFF, 1'b1);
    repeat (10) queue_tick(1'b0, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'h3333, 1'b1);
    queue_tick(1'b1, 16'h0000, 1'b0);
    wait_drained();

    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 0, 0, 250);
    run_phase(16'hFFFF, 16'd0, 16'd0, 47, 0, 250);
    run_phase(16'd1, 16'd32768, 16'd16384, 0, 47, 250);
    run_phase(VOLUME_RESET, DECAY_RESET, ATTACK_RESET, 27, 27, 400);

    // receiver holds off while ticks keep coming, so the input side backs up
    hold_active = 1'b1;
    run_phase(VOLUME_RESET, 16'd62000, 16'd30000, 0, 0, 100);
    hold_active = 1'b0;

    repeat (2) run_phase(CFG_WIDTH'($urandom), CFG_WIDTH'($urandom),
                         CFG_WIDTH'($urandom), 27, 27, 350);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0 && meter_expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
